// ===== src/cfd_pkg.sv =====
// chunk frame decoder package: header layout, status codes, config indexes, result type
// no dependencies; used by every other file of the decoder
package cfd_pkg;

	// byte position counter, saturating at all ones
	localparam int unsigned POS_W = 33;
	typedef logic [POS_W-1:0] pos_t;
	localparam pos_t POS_MAX = '1;

	// header layout, first byte position of each section
	localparam pos_t POS_VER    = 33'd4;
	localparam pos_t POS_FLAG   = 33'd5;
	localparam pos_t POS_ID_HI  = 33'd8;
	localparam pos_t POS_ID_LO  = 33'd16;
	localparam pos_t POS_STREAM = 33'd24;
	localparam pos_t POS_CHUNK  = 33'd28;
	localparam pos_t POS_LEN    = 33'd36;
	localparam pos_t HDR_BYTES  = 33'd40;

	// magic bytes at header positions zero to three
	localparam logic [7:0] MAGIC [4] = '{8'h41, 8'h56, 8'h46, 8'h31};

	// end-of-frame status, in reporting priority after ok
	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_TRUNC = 3'd1,
		ST_MAGIC = 3'd2,
		ST_HDR   = 3'd3,
		ST_LEN   = 3'd4
	} status_t;

	// configuration register indexes and reset values
	localparam int unsigned CFG_DATA_W = 32;
	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_FRAME_VERSION = 1'd0;
	localparam cfg_idx_t CFG_MAX_PAYLOAD   = 1'd1;
	localparam logic [7:0]  VERSION_RST     = 8'd1;
	localparam logic [31:0] MAX_PAYLOAD_RST = 32'd16777216;

	// one result word
	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        payload_valid;
		logic        frame_done;
		status_t     status;
		logic [63:0] transfer_id_high;
		logic [63:0] transfer_id_low;
		logic [31:0] stream_number;
		logic [63:0] chunk_number;
		logic        is_final_chunk;
		logic [31:0] payload_length;
	} res_t;

endpackage

// ===== src/cfd_if.sv =====
// valid/ready channel interfaces for the chunk frame decoder input and result words
// depends on cfd_pkg for the status type
interface cfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cfd_out_if;
	logic              valid;
	logic              ready;
	logic [7:0]        payload_byte;
	logic              payload_valid;
	logic              frame_done;
	cfd_pkg::status_t  status;
	logic [63:0]       transfer_id_high;
	logic [63:0]       transfer_id_low;
	logic [31:0]       stream_number;
	logic [63:0]       chunk_number;
	logic              is_final_chunk;
	logic [31:0]       payload_length;

	modport source (
		output valid, output payload_byte, output payload_valid, output frame_done,
		output status, output transfer_id_high, output transfer_id_low,
		output stream_number, output chunk_number, output is_final_chunk,
		output payload_length, input ready
	);
	modport sink (
		input valid, input payload_byte, input payload_valid, input frame_done,
		input status, input transfer_id_high, input transfer_id_low,
		input stream_number, input chunk_number, input is_final_chunk,
		input payload_length, output ready
	);
endinterface

// ===== src/cfd_hdr_parse.sv =====
// per-frame header parser: byte counter, sticky checks, header shift registers
// computes the result word for the current byte; depends on cfd_pkg
module cfd_hdr_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic [7:0]        frame_version,
	input  logic [31:0]       max_payload,
	output cfd_pkg::res_t     res
);

	cfd_pkg::pos_t pos_q, pos_inc, len_end;
	logic          magic_err_q, magic_err_d;
	logic          hdr_err_q, hdr_err_d;
	logic          final_q, final_d;
	logic [63:0]   id_hi_q, id_hi_d;
	logic [63:0]   id_lo_q, id_lo_d;
	logic [31:0]   stream_q, stream_d;
	logic [63:0]   chunk_q, chunk_d;
	logic [31:0]   len_q, len_d;
	logic          is_pay;
	cfd_pkg::status_t status;

	// field decode by byte position
	always_comb begin
		magic_err_d = magic_err_q;
		hdr_err_d   = hdr_err_q;
		final_d     = final_q;
		id_hi_d     = id_hi_q;
		id_lo_d     = id_lo_q;
		stream_d    = stream_q;
		chunk_d     = chunk_q;
		len_d       = len_q;
		is_pay      = 1'b0;
		priority if (pos_q < cfd_pkg::POS_VER) begin
			if (data_byte != cfd_pkg::MAGIC[pos_q[1:0]]) magic_err_d = 1'b1;
		end else if (pos_q == cfd_pkg::POS_VER) begin
			if (data_byte != frame_version) hdr_err_d = 1'b1;
		end else if (pos_q == cfd_pkg::POS_FLAG) begin
			if (data_byte > 8'd1) hdr_err_d = 1'b1;
			final_d = (data_byte == 8'd1);
		end else if (pos_q < cfd_pkg::POS_ID_HI) begin
			if (data_byte != 8'd0) hdr_err_d = 1'b1;
		end else if (pos_q < cfd_pkg::POS_ID_LO) begin
			id_hi_d = {id_hi_q[55:0], data_byte};
		end else if (pos_q < cfd_pkg::POS_STREAM) begin
			id_lo_d = {id_lo_q[55:0], data_byte};
		end else if (pos_q < cfd_pkg::POS_CHUNK) begin
			stream_d = {stream_q[23:0], data_byte};
		end else if (pos_q < cfd_pkg::POS_LEN) begin
			chunk_d = {chunk_q[55:0], data_byte};
		end else if (pos_q < cfd_pkg::HDR_BYTES) begin
			len_d = {len_q[23:0], data_byte};
		end else begin
			is_pay = 1'b1;
		end
	end

	// saturating count; the last byte of a well-formed frame sits at length + 39
	assign pos_inc = (pos_q == cfd_pkg::POS_MAX) ? pos_q : pos_q + 33'd1;
	assign len_end = {1'b0, len_d} + (cfd_pkg::HDR_BYTES - 33'd1);

	// end status by priority
	always_comb begin
		priority if (pos_inc < cfd_pkg::HDR_BYTES) begin
			status = cfd_pkg::ST_TRUNC;
		end else if (magic_err_d) begin
			status = cfd_pkg::ST_MAGIC;
		end else if (hdr_err_d) begin
			status = cfd_pkg::ST_HDR;
		end else if (len_d > max_payload || pos_q != len_end) begin
			status = cfd_pkg::ST_LEN;
		end else begin
			status = cfd_pkg::ST_OK;
		end
	end

	// result word; header fields only on the last byte
	always_comb begin
		res               = '0;
		res.payload_byte  = is_pay ? data_byte : 8'd0;
		res.payload_valid = is_pay;
		res.frame_done    = last_byte;
		res.status        = cfd_pkg::ST_OK;
		if (last_byte) begin
			res.status           = status;
			res.transfer_id_high = id_hi_d;
			res.transfer_id_low  = id_lo_d;
			res.stream_number    = stream_d;
			res.chunk_number     = chunk_d;
			res.is_final_chunk   = final_d;
			res.payload_length   = len_d;
		end
	end

	// frame state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			magic_err_q <= 1'b0;
			hdr_err_q   <= 1'b0;
			final_q     <= 1'b0;
			id_hi_q     <= '0;
			id_lo_q     <= '0;
			stream_q    <= '0;
			chunk_q     <= '0;
			len_q       <= '0;
		end else if (step) begin
			if (last_byte) begin
				pos_q       <= '0;
				magic_err_q <= 1'b0;
				hdr_err_q   <= 1'b0;
				final_q     <= 1'b0;
				id_hi_q     <= '0;
				id_lo_q     <= '0;
				stream_q    <= '0;
				chunk_q     <= '0;
				len_q       <= '0;
			end else begin
				pos_q       <= pos_inc;
				magic_err_q <= magic_err_d;
				hdr_err_q   <= hdr_err_d;
				final_q     <= final_d;
				id_hi_q     <= id_hi_d;
				id_lo_q     <= id_lo_d;
				stream_q    <= stream_d;
				chunk_q     <= chunk_d;
				len_q       <= len_d;
			end
		end
	end

endmodule

// ===== src/chunk_frame_decoder_top.sv =====
// chunk frame decoder top level: input register, header parser, result register
// depends on cfd_pkg, cfd_if.sv and cfd_hdr_parse
// an accepted byte is held in the input register; its result word then goes to the result register
// throughput: one byte per cycle; the two-stage valid/ready pipeline stalls only
// when the result register holds a word that is not taken
// reset: arst_n clears the pipeline, the frame state and sets the config registers
// to version 1 and max payload 16777216
module chunk_frame_decoder_top (
	input  logic                                clk,
	input  logic                                arst_n,
	cfd_in_if.sink                              in_ch,
	cfd_out_if.source                           out_ch,
	input  logic                                cfg_we,
	input  cfd_pkg::cfg_idx_t                   cfg_index,
	input  logic [cfd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic          valid_s1;
	logic [7:0]    data_s1;
	logic          last_s1;
	logic          out_valid_q;
	cfd_pkg::res_t res, res_q;
	logic [7:0]    frame_version_q;
	logic [31:0]   max_payload_q;
	logic          advance, step;

	// pipeline control
	assign advance      = !out_valid_q || out_ch.ready;
	assign step         = valid_s1 && advance;
	assign in_ch.ready  = !valid_s1 || advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_version_q <= cfd_pkg::VERSION_RST;
			max_payload_q   <= cfd_pkg::MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cfd_pkg::CFG_FRAME_VERSION: frame_version_q <= cfg_data[7:0];
				cfd_pkg::CFG_MAX_PAYLOAD:   max_payload_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			data_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	// header parse and status
	cfd_hdr_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.data_byte     (data_s1),
		.last_byte     (last_s1),
		.frame_version (frame_version_q),
		.max_payload   (max_payload_q),
		.res           (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) res_q <= res;
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.payload_byte     = res_q.payload_byte;
	assign out_ch.payload_valid    = res_q.payload_valid;
	assign out_ch.frame_done       = res_q.frame_done;
	assign out_ch.status           = res_q.status;
	assign out_ch.transfer_id_high = res_q.transfer_id_high;
	assign out_ch.transfer_id_low  = res_q.transfer_id_low;
	assign out_ch.stream_number    = res_q.stream_number;
	assign out_ch.chunk_number     = res_q.chunk_number;
	assign out_ch.is_final_chunk   = res_q.is_final_chunk;
	assign out_ch.payload_length   = res_q.payload_length;

	// a stepped word always lands in the result register
	a_step_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("stepped word lost before result register");

	// an empty result register never holds back the input
	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ch.ready)
		else $error("input stalled with empty result register");

	// status and header fields only on the last word of a frame
	a_mid_frame_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.frame_done |->
			res_q.status == cfd_pkg::ST_OK && res_q.payload_length == 32'd0)
		else $error("status reported mid frame");

endmodule

// ===== test/tb_chunk_frame_decoder_top.sv =====
`timescale 1ns / 1ps
// testbench for chunk_frame_decoder_top: sends frames byte by byte and checks every result word
// depends on cfd_pkg, cfd_if.sv and the decoder RTL
module tb_chunk_frame_decoder_top;

	localparam int HOLD_CYCLES = 150;
	localparam int FRAME_HDR_LEN = 40;
	localparam longint TIMEOUT_NS = 5_000_000;
	localparam logic [7:0] FRAME_TAG [4] = '{8'h41, 8'h56, 8'h46, 8'h31};

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfd_pkg::cfg_idx_t cfg_index;
	logic [cfd_pkg::CFG_DATA_W-1:0] cfg_data;

	cfd_in_if in_ch();
	cfd_out_if out_ch();

	chunk_frame_decoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// decoder state as predicted
	logic [7:0] ver_reg;
	logic [31:0] max_reg;
	cfd_pkg::pos_t at_pos;
	logic magic_bad;
	logic header_bad;
	logic [63:0] id_hi_acc;
	logic [63:0] id_lo_acc;
	logic [31:0] stream_acc;
	logic [63:0] chunk_acc;
	logic [31:0] length_acc;
	logic final_seen;

	cfd_pkg::res_t decoded_words[$];
	logic [7:0] frame_buf[$];
	int bytes_sent;
	int words_seen;
	int fault_count;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_ticket;
	int hold_seen;
	int hold_left;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("Test completed with failures");
		$finish;
	end

	// frame state back to its start
	function void clear_frame_state();
		at_pos = '0;
		magic_bad = 1'b0;
		header_bad = 1'b0;
		id_hi_acc = '0;
		id_lo_acc = '0;
		stream_acc = '0;
		chunk_acc = '0;
		length_acc = '0;
		final_seen = 1'b0;
	endfunction

	// expected result word for one accepted byte
	function cfd_pkg::res_t decode_byte(logic [7:0] b, logic last);
		cfd_pkg::res_t r;
		logic in_payload;
		cfd_pkg::pos_t total;
		r = '0;
		in_payload = 1'b0;
		if (at_pos < 4) begin
			if (b != FRAME_TAG[at_pos[1:0]]) magic_bad = 1'b1;
		end else if (at_pos == 4) begin
			if (b != ver_reg) header_bad = 1'b1;
		end else if (at_pos == 5) begin
			if (b > 8'd1) header_bad = 1'b1;
			final_seen = (b == 8'd1);
		end else if (at_pos < 8) begin
			if (b != 8'd0) header_bad = 1'b1;
		end else if (at_pos < 16) begin
			id_hi_acc = {id_hi_acc[55:0], b};
		end else if (at_pos < 24) begin
			id_lo_acc = {id_lo_acc[55:0], b};
		end else if (at_pos < 28) begin
			stream_acc = {stream_acc[23:0], b};
		end else if (at_pos < 36) begin
			chunk_acc = {chunk_acc[55:0], b};
		end else if (at_pos < FRAME_HDR_LEN) begin
			length_acc = {length_acc[23:0], b};
		end else begin
			in_payload = 1'b1;
		end
		// counter stops at all ones
		if (at_pos != '1) at_pos = at_pos + 33'd1;

		r.payload_byte = in_payload ? b : 8'd0;
		r.payload_valid = in_payload;
		r.frame_done = last;
		if (last) begin
			total = at_pos;
			if (total < FRAME_HDR_LEN) r.status = cfd_pkg::ST_TRUNC;
			else if (magic_bad) r.status = cfd_pkg::ST_MAGIC;
			else if (header_bad) r.status = cfd_pkg::ST_HDR;
			else if (length_acc > max_reg || (total - 33'd40) != {1'b0, length_acc})
				r.status = cfd_pkg::ST_LEN;
			else r.status = cfd_pkg::ST_OK;
			r.transfer_id_high = id_hi_acc;
			r.transfer_id_low = id_lo_acc;
			r.stream_number = stream_acc;
			r.chunk_number = chunk_acc;
			r.is_final_chunk = final_seen;
			r.payload_length = length_acc;
			clear_frame_state();
		end
		return r;
	endfunction

	task report_mismatch(string msg);
		fault_count++;
		if (fault_count <= 40) $display("[%0t] word %0d: %s", $time, words_seen, msg);
	endtask

	task compare_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// compare one accepted result word with the oldest prediction
	task check_word();
		cfd_pkg::res_t got;
		cfd_pkg::res_t want;
		got.payload_byte = out_ch.payload_byte;
		got.payload_valid = out_ch.payload_valid;
		got.frame_done = out_ch.frame_done;
		got.status = out_ch.status;
		got.transfer_id_high = out_ch.transfer_id_high;
		got.transfer_id_low = out_ch.transfer_id_low;
		got.stream_number = out_ch.stream_number;
		got.chunk_number = out_ch.chunk_number;
		got.is_final_chunk = out_ch.is_final_chunk;
		got.payload_length = out_ch.payload_length;
		words_seen++;
		if (decoded_words.size() == 0) begin
			report_mismatch("result word with nothing pending");
		end else begin
			want = decoded_words.pop_front();
			compare_field("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
			compare_field("payload_valid", 64'(got.payload_valid), 64'(want.payload_valid));
			compare_field("frame_done", 64'(got.frame_done), 64'(want.frame_done));
			compare_field("status", 64'(got.status), 64'(want.status));
			compare_field("transfer_id_high", got.transfer_id_high, want.transfer_id_high);
			compare_field("transfer_id_low", got.transfer_id_low, want.transfer_id_low);
			compare_field("stream_number", 64'(got.stream_number), 64'(want.stream_number));
			compare_field("chunk_number", got.chunk_number, want.chunk_number);
			compare_field("is_final_chunk", 64'(got.is_final_chunk), 64'(want.is_final_chunk));
			compare_field("payload_length", 64'(got.payload_length), 64'(want.payload_length));
		end
	endtask

	// result side: sample at the edge, values from before it
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) check_word();
		end
	end

	// result ready: random stalls, or a long hold-off when asked for
	initial begin
		out_ch.ready <= 1'b0;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_ticket != hold_seen) begin
				hold_seen = hold_ticket;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// offer one byte, with random gaps before it, until accepted
	task send_byte(logic [7:0] b, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.last_byte <= last;
		do @(posedge clk); while (!in_ch.ready);
		decoded_words = {decoded_words, decode_byte(b, last)};
		bytes_sent++;
	endtask

	// drop valid and wait for every pending word
	task wait_idle();
		in_ch.valid <= 1'b0;
		while (decoded_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_reg(cfd_pkg::cfg_idx_t idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == cfd_pkg::CFG_FRAME_VERSION) ver_reg = val[7:0];
		else max_reg = val;
		@(posedge clk);
	endtask

	function logic [63:0] rand_wide();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task put_be(logic [63:0] v, int nbytes);
		for (int i = nbytes - 1; i >= 0; i--) frame_buf = {frame_buf, v[8*i +: 8]};
	endtask

	// fresh frame buffer holding a 40-byte header
	task start_frame(logic [7:0] ver, logic [7:0] flag, logic [15:0] rsvd,
			logic [63:0] id_hi, logic [63:0] id_lo, logic [31:0] stream,
			logic [63:0] chunk, logic [31:0] len);
		frame_buf = {};
		for (int i = 0; i < 4; i++) frame_buf = {frame_buf, FRAME_TAG[i]};
		frame_buf = {frame_buf, ver};
		frame_buf = {frame_buf, flag};
		put_be(64'(rsvd), 2);
		put_be(id_hi, 8);
		put_be(id_lo, 8);
		put_be(64'(stream), 4);
		put_be(chunk, 8);
		put_be(64'(len), 4);
	endtask

	task add_payload(int n);
		for (int i = 0; i < n; i++) frame_buf = {frame_buf, 8'($urandom_range(255))};
	endtask

	task set_length(logic [31:0] len);
		for (int i = 0; i < 4; i++) frame_buf[36+i] = len[8*(3-i) +: 8];
	endtask

	// send buffer bytes first..stop-1; closes puts the end mark on the final one
	task send_bytes(int first, int stop, bit closes, bit noisy);
		for (int i = first; i < stop; i++)
			send_byte(frame_buf[i], (closes && i == stop - 1) ||
				(noisy && $urandom_range(15) == 0));
	endtask

	task send_all();
		send_bytes(0, frame_buf.size(), 1'b1, 1'b0);
	endtask

	task test_header_checks();
		send_idle_pct = 33;
		recv_idle_pct = 64;
		// clean frame, short payload
		start_frame(ver_reg, 8'd0, 16'd0, rand_wide(), rand_wide(), $urandom, rand_wide(), 3);
		add_payload(3);
		send_all();
		// all-ones header fields, final flag, payload bytes at both ends
		start_frame(ver_reg, 8'd1, 16'd0, '1, '1, '1, '1, 2);
		frame_buf = {frame_buf, 8'h00};
		frame_buf = {frame_buf, 8'hFF};
		send_all();
		// all-zero fields, empty payload
		start_frame(ver_reg, 8'd0, 16'd0, '0, '0, '0, '0, 0);
		send_all();
		// one-byte frame, then a header cut before its last length byte
		start_frame(ver_reg, 8'd1, 16'd0, '1, '1, '1, '1, 32'hA5A5_A5A5);
		send_bytes(0, 1, 1'b1, 1'b0);
		send_bytes(0, 39, 1'b1, 1'b0);
		// short frame with a bad tag: truncation wins
		frame_buf[0] = 8'h00;
		send_bytes(0, 12, 1'b1, 1'b0);
		// bad tag together with a bad version: tag wins
		start_frame(ver_reg ^ 8'h80, 8'd0, 16'd0, rand_wide(), rand_wide(), $urandom,
			rand_wide(), 0);
		frame_buf[3] ^= 8'h01;
		send_all();
		// wrong version and wrong length: header wins
		start_frame(ver_reg + 8'd1, 8'd0, 16'd0, rand_wide(), rand_wide(), $urandom,
			rand_wide(), 4);
		add_payload(2);
		send_all();
		// flag above one
		start_frame(ver_reg, 8'd2, 16'd0, rand_wide(), rand_wide(), $urandom, rand_wide(), 0);
		send_all();
		start_frame(ver_reg, 8'hFF, 16'd0, rand_wide(), rand_wide(), $urandom, rand_wide(), 0);
		send_all();
		// reserved bytes not zero
		start_frame(ver_reg, 8'd0, 16'h0080, rand_wide(), rand_wide(), $urandom, rand_wide(), 0);
		send_all();
		start_frame(ver_reg, 8'd1, 16'h0100, rand_wide(), rand_wide(), $urandom, rand_wide(), 1);
		add_payload(1);
		send_all();
		// length one above and one below the bytes sent
		start_frame(ver_reg, 8'd0, 16'd0, rand_wide(), rand_wide(), $urandom, rand_wide(), 5);
		add_payload(4);
		send_all();
		start_frame(ver_reg, 8'd0, 16'd0, rand_wide(), rand_wide(), $urandom, rand_wide(), 4);
		add_payload(5);
		send_all();
		// length far beyond the limit
		start_frame(ver_reg, 8'd0, 16'd0, rand_wide(), rand_wide(), $urandom, rand_wide(),
			32'hFFFF_FFFF);
		add_payload(1);
		send_all();
		wait_idle();
	endtask

	task test_register_extremes();
		// highest version, nothing allowed in the payload
		write_reg(cfd_pkg::CFG_FRAME_VERSION, 32'd255);
		write_reg(cfd_pkg::CFG_MAX_PAYLOAD, 32'd0);
		start_frame(8'd255, 8'd0, 16'd0, rand_wide(), rand_wide(), $urandom, rand_wide(), 0);
		send_all();
		start_frame(8'd255, 8'd1, 16'd0, rand_wide(), rand_wide(), $urandom, rand_wide(), 1);
		add_payload(1);
		send_all();
		start_frame(8'd1, 8'd0, 16'd0, rand_wide(), rand_wide(), $urandom, rand_wide(), 0);
		send_all();
		wait_idle();
		// version zero, no payload limit
		write_reg(cfd_pkg::CFG_FRAME_VERSION, 32'd0);
		write_reg(cfd_pkg::CFG_MAX_PAYLOAD, 32'hFFFF_FFFF);
		start_frame(8'd0, 8'd1, 16'd0, rand_wide(), rand_wide(), $urandom, rand_wide(), 0);
		send_all();
		start_frame(8'd0, 8'd0, 16'd0, rand_wide(), rand_wide(), $urandom, rand_wide(), 5);
		add_payload(5);
		send_all();
		start_frame(8'd0, 8'd0, 16'd0, rand_wide(), rand_wide(), $urandom, rand_wide(),
			32'hFFFF_FFFF);
		add_payload(2);
		send_all();
		wait_idle();
	endtask

	// mostly clean frames with random content, some broken, some noise
	task random_frame();
		int kind;
		int n;
		int cut;
		bit noisy;
		kind = $urandom_range(99);
		n = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 24);
		noisy = 1'b0;
		start_frame(ver_reg, 8'($urandom_range(1)), 16'd0, rand_wide(), rand_wide(),
			32'(rand_wide()), rand_wide(), n);
		add_payload(n);
		cut = frame_buf.size();
		if (kind >= 88) begin
			// noise: random bytes with stray end marks
			frame_buf = {};
			add_payload($urandom_range(1, 30));
			cut = frame_buf.size();
			noisy = 1'b1;
		end else if (kind >= 70) begin
			case ($urandom_range(6))
				0: frame_buf[$urandom_range(3)] ^= 8'($urandom_range(1, 255));
				1: frame_buf[4] ^= 8'($urandom_range(1, 255));
				2: frame_buf[5] = 8'($urandom_range(2, 255));
				3: frame_buf[6 + $urandom_range(1)] = 8'($urandom_range(1, 255));
				4: set_length(32'(n + $urandom_range(1, 3)));
				5: cut = $urandom_range(1, FRAME_HDR_LEN - 1);
				default: set_length($urandom);
			endcase
		end
		send_bytes(0, cut, 1'b1, noisy);
	endtask

	task test_random_traffic(int target, int send_pct, int recv_pct, logic [7:0] ver,
			logic [31:0] maxp);
		int start_count;
		wait_idle();
		write_reg(cfd_pkg::CFG_FRAME_VERSION, {24'd0, ver});
		write_reg(cfd_pkg::CFG_MAX_PAYLOAD, maxp);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start_count = bytes_sent;
		while (bytes_sent - start_count < target) random_frame();
		wait_idle();
	endtask

	task test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// result side holds off while bytes keep coming
		hold_ticket <= hold_ticket + 1;
		start_frame(ver_reg, 8'd1, 16'd0, rand_wide(), rand_wide(), $urandom, rand_wide(), 60);
		add_payload(60);
		send_all();
		wait_idle();
		// sender pauses mid-frame until all words are back
		start_frame(ver_reg, 8'd0, 16'd0, rand_wide(), rand_wide(), $urandom, rand_wide(), 10);
		add_payload(10);
		send_bytes(0, 20, 1'b0, 1'b0);
		wait_idle();
		send_bytes(20, frame_buf.size(), 1'b1, 1'b0);
		wait_idle();
	endtask

	// stimulus
	initial begin
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data_byte <= 8'd0;
		in_ch.last_byte <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= cfd_pkg::CFG_FRAME_VERSION;
		cfg_data <= '0;
		hold_ticket <= 0;
		bytes_sent = 0;
		words_seen = 0;
		fault_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		ver_reg = cfd_pkg::VERSION_RST;
		max_reg = cfd_pkg::MAX_PAYLOAD_RST;
		clear_frame_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_checks();
		test_register_extremes();
		test_random_traffic(220, 33, 64, 8'($urandom_range(255)), 32'd20);
		test_random_traffic(220, 64, 33, 8'd255, 32'hFFFF_FFFF);
		test_random_traffic(220, 0, 0, 8'd0, cfd_pkg::MAX_PAYLOAD_RST);
		test_output_backpressure();

		if (fault_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/cfd_pkg.sv
src/cfd_if.sv
src/cfd_hdr_parse.sv
src/chunk_frame_decoder_top.sv
test/tb_chunk_frame_decoder_top.sv
